@@ design/cmrm_pkg.sv @@
// ----------------------------------------------------------------------------
// cmrm_pkg: shared constants and types
// Widths, register indexes and status codes for the address core.
// ----------------------------------------------------------------------------
package cmrm_pkg;

  localparam int MAX_DIMS_DEF = 4;
  localparam int EXT_REGS     = 4;
  localparam int IDX_W        = 32;
  localparam int EXT_W        = 16;
  localparam int EB_W         = 11;
  localparam int OFS_W        = 42;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MAJOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ESIZE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic                 column_major;
    logic [2:0]           axes;
    logic [EB_W-1:0]      element_bytes;
  } cfg_t;

endpackage

@@ design/column_major_to_row_major_address_core.sv @@
// ----------------------------------------------------------------------------
// column_major_to_row_major_address_core
// The chain has the same depth for any MAX_DIMS: all four axis slots of 32
// restoring steps plus one accumulate stay in it. Throughput: one item per
// cycle while busy is low. busy is high after a register write and after
// reset while the element count settles.
// The receiver cannot stall. Reset restores the registers and drops items.
// ----------------------------------------------------------------------------
module column_major_to_row_major_address_core
  import cmrm_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IDX_W-1:0]      in_linear_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_source_index,
  output logic [OFS_W-1:0]      out_source_byte_offset,
  output logic [OFS_W-1:0]      out_dest_byte_offset,
  output logic [1:0]            out_status
);

  localparam int LIM  = (MAX_DIMS < EXT_REGS) ? MAX_DIMS : EXT_REGS;
  localparam int STG  = IDX_W + 1;         // 32 divide steps + 1 accumulate
  localparam int DEP  = STG * EXT_REGS;    // reorder section depth
  localparam int CNT_W = IDX_W + 1;

  // ---------------- configuration ----------------
  logic                 colmaj_r;
  logic [2:0]           ndims_r;
  logic [EXT_W-1:0]     ext_r [EXT_REGS];
  logic [EB_W-1:0]      eb_r;
  logic [2:0]           settle_r;

  assign cfg_ready = 1'b1;
  // Hold off new items until the staged element count reflects the registers.
  assign busy      = (settle_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colmaj_r <= 1'b0;
      ndims_r  <= '0;
      for (int i = 0; i < EXT_REGS; i++) ext_r[i] <= EXT_W'(1);
      eb_r     <= EB_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMN_MAJOR:  colmaj_r <= cfg_data[0];
        REG_NUM_DIMS:      ndims_r  <= cfg_data[2:0];
        REG_EXTENT_0:      ext_r[0] <= cfg_data[EXT_W-1:0];
        REG_EXTENT_1:      ext_r[1] <= cfg_data[EXT_W-1:0];
        REG_EXTENT_2:      ext_r[2] <= cfg_data[EXT_W-1:0];
        REG_EXTENT_3:      ext_r[3] <= cfg_data[EXT_W-1:0];
        REG_ELEMENT_BYTES: eb_r     <= cfg_data[EB_W-1:0];
        default: ;
      endcase
    end
  end

  // Count down the settle window after reset or any register write.
  always_ff @(posedge clk) begin
    if (!rst_n)                      settle_r <= 3'(EXT_REGS);
    else if (cfg_valid && cfg_ready) settle_r <= 3'(EXT_REGS);
    else if (settle_r != '0)         settle_r <= settle_r - 3'd1;
  end

  // Axes in use, clamped; the user keeps them stable while items fly (not enforced).
  logic [2:0] axes;
  always_comb begin
    axes = ndims_r;
    if (32'(ndims_r) > LIM) axes = 3'(LIM);
  end

  // Element count, saturating, built in stages off the config (static).
  logic [CNT_W-1:0] cnt_r [EXT_REGS+1];
  logic [CNT_W+EXT_W-1:0] cprod [EXT_REGS];
  always_comb begin
    for (int d = 0; d < EXT_REGS; d++) begin
      cprod[d] = cnt_r[d] * ext_r[d];
    end
  end
  always_ff @(posedge clk) begin
    cnt_r[0] <= CNT_W'(1);
    for (int d = 0; d < EXT_REGS; d++) begin
      if (32'(d) >= 32'(axes)) cnt_r[d+1] <= cnt_r[d];
      else if (cprod[d] > (CNT_W+EXT_W)'(64'h1_0000_0000))
        cnt_r[d+1] <= {1'b1, {IDX_W{1'b0}}};
      else cnt_r[d+1] <= cprod[d][CNT_W-1:0];
    end
  end

  // Column-major strides: stride[d] = product of extents below d (mod 2^32).
  logic [IDX_W-1:0] strd_r [EXT_REGS];
  logic [IDX_W+EXT_W-1:0] sprod [EXT_REGS];
  always_comb begin
    for (int d = 0; d < EXT_REGS; d++) sprod[d] = strd_r[d] * ext_r[d];
  end
  always_ff @(posedge clk) begin
    strd_r[0] <= IDX_W'(1);
    for (int d = 1; d < EXT_REGS; d++) strd_r[d] <= sprod[d-1][IDX_W-1:0];
  end

  // ---------------- stage A: range check ----------------
  logic             a_v_r;
  logic [IDX_W-1:0] a_pos_r;
  logic [1:0]       a_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= start && !busy;
    a_pos_r <= in_linear_index;
    if (eb_r == '0) a_st_r <= ST_ESIZE;
    else if ({1'b0, in_linear_index} >= cnt_r[EXT_REGS]) a_st_r <= ST_RANGE;
    else a_st_r <= ST_OK;
  end

  // ---------------- reorder chain ----------------
  // Axes are processed last first: chain slot k handles axis EXT_REGS-1-k.
  // Axes not in use or with extent zero pass through unchanged.
  logic             v_r   [DEP+1];
  logic [IDX_W-1:0] pos_r [DEP+1];
  logic [1:0]       st_r  [DEP+1];
  logic [IDX_W-1:0] src_r [EXT_REGS+1];
  logic [IDX_W-1:0] rest_r[EXT_REGS+1];

  // pipeline of side data along the full depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DEP; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= a_v_r;
      for (int i = 1; i <= DEP; i++) v_r[i] <= v_r[i-1];
    end
    pos_r[0] <= a_pos_r;
    st_r[0]  <= a_st_r;
    for (int i = 1; i <= DEP; i++) begin
      pos_r[i] <= pos_r[i-1];
      st_r[i]  <= st_r[i-1];
    end
  end

  assign rest_r[0] = pos_r[0];
  assign src_r[0]  = '0;

  for (genvar k = 0; k < EXT_REGS; k++) begin : g_axis
    localparam int AX = EXT_REGS - 1 - k;
    logic [EXT_W:0]   rem [IDX_W+1];
    logic [IDX_W-1:0] quo [IDX_W+1];
    logic [IDX_W-1:0] srcd [IDX_W];
    logic             use_ax;
    logic [IDX_W-1:0] q_fix;
    logic [IDX_W-1:0] rs_r;
    logic [IDX_W-1:0] sr_r;
    logic [IDX_W+EXT_W-1:0] term;

    assign use_ax = (32'(AX) < 32'(axes)) && (ext_r[AX] != '0);
    assign rem[0] = '0;
    assign quo[0] = rest_r[k];

    // carry the partial source index alongside the divider
    always_ff @(posedge clk) begin
      srcd[0] <= src_r[k];
      for (int j = 1; j < IDX_W; j++) srcd[j] <= srcd[j-1];
    end

    for (genvar j = 0; j < IDX_W; j++) begin : g_step
      cmrm_div_stage u_step (
        .clk     (clk),
        .rem_in  (rem[j]),
        .quo_in  (quo[j]),
        .divisor (ext_r[AX]),
        .rem_out (rem[j+1]),
        .quo_out (quo[j+1])
      );
    end

    // carry the undivided rest for a bypassed axis
    logic [IDX_W-1:0] orig [IDX_W+1];
    assign orig[0] = rest_r[k];
    for (genvar j = 0; j < IDX_W; j++) begin : g_orig
      always_ff @(posedge clk) orig[j+1] <= orig[j];
    end

    assign q_fix = use_ax ? quo[IDX_W] : orig[IDX_W];
    assign term  = rem[IDX_W][EXT_W-1:0] * strd_r[AX];

    always_ff @(posedge clk) begin
      rs_r <= q_fix;
      sr_r <= use_ax ? (srcd[IDX_W-1] + term[IDX_W-1:0]) : srcd[IDX_W-1];
    end
    assign rest_r[k+1] = rs_r;
    assign src_r[k+1]  = sr_r;
  end

  // ---------------- output: multiply and format ----------------
  logic             m_v_r;
  logic [1:0]       m_st_r;
  logic [IDX_W-1:0] m_src_r;
  logic [IDX_W-1:0] m_pos_r;
  logic [IDX_W-1:0] sel_src;

  always_comb begin
    if (!colmaj_r)       sel_src = pos_r[DEP];
    else if (axes == '0) sel_src = '0;
    else                 sel_src = src_r[EXT_REGS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else        m_v_r <= v_r[DEP];
    m_st_r  <= st_r[DEP];
    m_src_r <= (st_r[DEP] == ST_OK) ? sel_src : '0;
    m_pos_r <= (st_r[DEP] == ST_OK) ? pos_r[DEP] : '0;
  end

  logic [IDX_W+EB_W-1:0] sprd, dprd;
  assign sprd = m_src_r * eb_r;
  assign dprd = m_pos_r * eb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= m_v_r;
    out_source_index       <= m_src_r;
    out_source_byte_offset <= OFS_W'(sprd);
    out_dest_byte_offset   <= OFS_W'(dprd);
    out_status             <= m_st_r;
  end

endmodule

@@ design/cmrm_div_stage.sv @@
// ----------------------------------------------------------------------------
// cmrm_div_stage: one radix-2 restoring division step
// Registered step of rest / extent; shifts one quotient bit per stage.
// ----------------------------------------------------------------------------
module cmrm_div_stage
  import cmrm_pkg::*;
(
  input  logic             clk,
  input  logic [EXT_W:0]   rem_in,
  input  logic [IDX_W-1:0] quo_in,
  input  logic [EXT_W-1:0] divisor,
  output logic [EXT_W:0]   rem_out,
  output logic [IDX_W-1:0] quo_out
);

  logic [EXT_W+1:0] trial;
  logic [EXT_W+1:0] sub;

  always_comb begin
    trial = {rem_in, quo_in[IDX_W-1]};
    sub   = trial - {2'b00, divisor};
  end

  // rem_in < divisor for a nonzero divisor, so the result fits in EXT_W+1 bits
  always_ff @(posedge clk) begin
    if (!sub[EXT_W+1]) begin
      rem_out <= sub[EXT_W:0];
      quo_out <= {quo_in[IDX_W-2:0], 1'b1};
    end else begin
      rem_out <= trial[EXT_W:0];
      quo_out <= {quo_in[IDX_W-2:0], 1'b0};
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: address core testbench
// Drives destination positions through the core under a series of register
// settings, predicts each source index, byte offsets and status, and checks
// every result in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb;
  import cmrm_pkg::*;

  localparam int LATENCY   = 3 + 33 * EXT_REGS;
  localparam int CYCLE_CAP = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic [OFS_W-1:0] src_ofs;
    logic [OFS_W-1:0] dst_ofs;
    logic [1:0]       status;
  } addr_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [IDX_W-1:0]      in_linear_index;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  logic [IDX_W-1:0]      out_source_index;
  logic [OFS_W-1:0]      out_source_byte_offset;
  logic [OFS_W-1:0]      out_dest_byte_offset;
  logic [1:0]            out_status;

  // Shadow copy of the register file.
  logic             sh_colmaj;
  logic [2:0]       sh_dims;
  logic [EXT_W-1:0] sh_ext [EXT_REGS];
  logic [EB_W-1:0]  sh_eb;

  addr_res_t pending_addrs[$];
  int        mismatches;
  int        cycles;

  column_major_to_row_major_address_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_linear_index        (in_linear_index),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_source_index       (out_source_index),
    .out_source_byte_offset (out_source_byte_offset),
    .out_dest_byte_offset   (out_dest_byte_offset),
    .out_status             (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // Compute the expected result for one destination position.
  function automatic addr_res_t predict_addr(logic [IDX_W-1:0] pos);
    addr_res_t  r;
    int         axes;
    logic [63:0] total;
    logic [63:0] rest;
    logic [63:0] stride;
    logic [63:0] src;
    logic [63:0] idx [EXT_REGS];
    r = '0;
    axes = (sh_dims > MAX_DIMS_DEF) ? MAX_DIMS_DEF : sh_dims;
    if (sh_eb == 0) begin
      r.status = ST_ESIZE;
      return r;
    end
    total = 1;
    for (int d = 0; d < axes; d++) begin
      total = total * sh_ext[d];
      if (total > 64'h1_0000_0000) total = 64'h1_0000_0000;
    end
    if (64'(pos) >= total) begin
      r.status = ST_RANGE;
      return r;
    end
    if (!sh_colmaj) begin
      src = pos;
    end else begin
      // Split last axis first, then rebuild with axis 0 at stride 1.
      rest = pos;
      for (int d = axes - 1; d >= 0; d--) begin
        idx[d] = rest % sh_ext[d];
        rest   = rest / sh_ext[d];
      end
      src = 0;
      stride = 1;
      for (int d = 0; d < axes; d++) begin
        src    = src + idx[d] * stride;
        stride = stride * sh_ext[d];
      end
      src = src & 64'hFFFF_FFFF;
    end
    r.src     = src[IDX_W-1:0];
    r.src_ofs = OFS_W'(src * sh_eb);
    r.dst_ofs = OFS_W'(64'(pos) * sh_eb);
    r.status  = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    addr_res_t e;
    if (rst_n && out_valid) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("unexpected result", out_source_index, 0);
      end else begin
        e = pending_addrs.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_source_index !== e.src)
          report_mismatch("source_index", out_source_index, e.src);
        if (out_source_byte_offset !== e.src_ofs)
          report_mismatch("source_byte_offset", out_source_byte_offset, e.src_ofs);
        if (out_dest_byte_offset !== e.dst_ofs)
          report_mismatch("dest_byte_offset", out_dest_byte_offset, e.dst_ofs);
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one item: hold start until the core takes it; start stays high so
  // the next item can follow at once, and the caller drops it when idling.
  task automatic send_item(logic [IDX_W-1:0] pos);
    start           <= 1'b1;
    in_linear_index <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_addrs.insert(pending_addrs.size(), predict_addr(pos));
  endtask

  task automatic send_with_gap(logic [IDX_W-1:0] pos);
    int g;
    send_item(pos);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait for every predicted result, then the pipeline depth.
  task automatic drain();
    start <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write one register; cfg_valid stays high so writes can follow back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COLUMN_MAJOR:  sh_colmaj = val[0];
      REG_NUM_DIMS:      sh_dims   = val[2:0];
      REG_EXTENT_0:      sh_ext[0] = val;
      REG_EXTENT_1:      sh_ext[1] = val;
      REG_EXTENT_2:      sh_ext[2] = val;
      REG_EXTENT_3:      sh_ext[3] = val;
      REG_ELEMENT_BYTES: sh_eb     = val[EB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic cm, logic [2:0] nd, logic [15:0] e0, logic [15:0] e1,
                           logic [15:0] e2, logic [15:0] e3, logic [15:0] eb);
    drain();
    write_reg(REG_COLUMN_MAJOR, 16'(cm));
    write_reg(REG_NUM_DIMS, 16'(nd));
    write_reg(REG_EXTENT_0, e0);
    write_reg(REG_EXTENT_1, e1);
    write_reg(REG_EXTENT_2, e2);
    write_reg(REG_EXTENT_3, e3);
    write_reg(REG_ELEMENT_BYTES, eb);
    cfg_valid <= 1'b0;
  endtask

  // Product of extents in use, capped at 2^32, for picking in-range positions.
  function automatic logic [63:0] shape_total();
    logic [63:0] t;
    t = 1;
    for (int d = 0; d < ((sh_dims > 4) ? 4 : sh_dims); d++) begin
      t = t * sh_ext[d];
      if (t > 64'h1_0000_0000) t = 64'h1_0000_0000;
    end
    return t;
  endfunction

  function automatic logic [IDX_W-1:0] pick_pos();
    logic [63:0] t;
    t = shape_total();
    if ($urandom_range(0, 9) == 0 || t == 0) return $urandom();
    if ($urandom_range(0, 9) == 0) return IDX_W'(t - 1);
    return IDX_W'({$urandom(), $urandom()} % t);
  endfunction

  task automatic test_reset_values();
    send_item(32'd0);
    send_item(32'd1);
    send_item(32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    // Small 3-D column-major array, edges of the range.
    set_shape(1'b1, 3'd3, 16'd3, 16'd4, 16'd5, 16'd7, 16'd4);
    send_item(32'd0);
    send_item(32'd59);
    send_item(32'd60);
    send_item(32'd17);
    // Zero element size wins over out of range.
    drain();
    write_reg(REG_ELEMENT_BYTES, 16'd0);
    cfg_valid <= 1'b0;
    send_item(32'd5);
    send_item(32'hFFFF_FFFF);
    // Oversized element, widest extents, saturating count, too many axes.
    set_shape(1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h07FF);
    send_item(32'hFFFF_FFFF);
    send_item(32'h8000_0001);
    send_item(32'd0);
    // Zero extent makes everything out of range.
    set_shape(1'b1, 3'd2, 16'd9, 16'd0, 16'd1, 16'd1, 16'd1024);
    send_item(32'd0);
    send_item(32'd3);
    // Zero axes in column-major mode, then row-major pass-through.
    set_shape(1'b1, 3'd0, 16'd5, 16'd5, 16'd5, 16'd5, 16'd8);
    send_item(32'd0);
    send_item(32'd1);
    set_shape(1'b0, 3'd4, 16'd2, 16'd3, 16'd4, 16'd5, 16'd1);
    send_item(32'd119);
    send_item(32'd120);
    send_item(32'd77);
    // Unknown register index is ignored.
    drain();
    write_reg(REG_UNUSED, 16'hABCD);
    cfg_valid <= 1'b0;
    send_item(32'd10);
  endtask

  task automatic test_random();
    logic [15:0] ext [4];
    for (int ph = 0; ph < 16; ph++) begin
      for (int d = 0; d < 4; d++) begin
        case ($urandom_range(0, 9))
          0:       ext[d] = 16'hFFFF;
          1:       ext[d] = 16'd0;
          2:       ext[d] = 16'd1;
          3, 4:    ext[d] = 16'($urandom());
          default: ext[d] = 16'($urandom_range(2, 40));
        endcase
      end
      set_shape($urandom_range(0, 3) != 0, 3'($urandom_range(0, 7)), ext[0], ext[1],
                ext[2], ext[3], ($urandom_range(0, 15) == 0) ? 16'd0 :
                ($urandom_range(0, 7) == 0) ? 16'h07FF : 16'($urandom_range(1, 1024)));
      for (int i = 0; i < 50; i++) begin
        // Sender waits once per phase until all results are back.
        if (i == 25) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending_addrs.size() != 0) @(posedge clk);
        end
        if (ph % 4 == 0) send_item(pick_pos());
        else send_with_gap(pick_pos());
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_linear_index = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    cycles          = 0;
    mismatches      = 0;
    sh_colmaj       = 1'b0;
    sh_dims         = '0;
    sh_eb           = 11'd1;
    for (int d = 0; d < EXT_REGS; d++) sh_ext[d] = 16'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/cmrm_pkg.sv
design/cmrm_div_stage.sv
design/column_major_to_row_major_address_core.sv
sim/tb.sv
